// File: src/pwfd_pkg.sv
// Shared types and constants for the protobuf wire field decoder.
`timescale 1ns / 1ps
`default_nettype none

package pwfd_pkg;

    // Default parameter values.
    localparam int PWFD_LENGTH_BITS      = 32;
    localparam int PWFD_MAX_VARINT_BYTES = 10;

    // Byte counter width; it covers key, fixed and varint byte positions.
    localparam int CNT_W = 4;

    // Depth of the queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] FIXED32_BYTES = CNT_W'(4);
    localparam logic [CNT_W-1:0] FIXED64_BYTES = CNT_W'(8);
    localparam logic [CNT_W-1:0] KEY_MAX_CNT   = CNT_W'(4);

    // Result kinds.
    localparam logic [1:0] KIND_SCALAR  = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Wire types.
    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_DELIM   = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    // End status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOSS = 2'd1;
    localparam logic [1:0] ST_EOM  = 2'd2;

    // One queue entry: everything a single input byte produces.
    typedef struct packed {
        logic        has_prim;
        logic [1:0]  kind;
        logic [28:0] field_number;
        logic [2:0]  wtype;
        logic [63:0] value;
        logic        has_end;
        logic [1:0]  end_status;
    } t_entry;

endpackage

`default_nettype wire

// File: src/pwfd_front.sv
// Byte parser: keeps the field parse state and classifies each byte into a queue entry.
`timescale 1ns / 1ps
`default_nettype none

module pwfd_front
    import pwfd_pkg::*;
#(
    parameter int LENGTH_BITS      = PWFD_LENGTH_BITS,
    parameter int MAX_VARINT_BYTES = PWFD_MAX_VARINT_BYTES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_push,
    output t_entry          o_entry
);

    typedef enum logic [4:0] {
        PH_KEY     = 5'b00001,
        PH_VARINT  = 5'b00010,
        PH_FIXED   = 5'b00100,
        PH_LEN     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [31:0]            r_key, n_key;
    logic [63:0]            r_val, n_val;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic                   r_err, n_err;

    logic [6:0]  w_g;
    logic        w_cont;
    logic [6:0]  w_sh7;
    logic [31:0] w_key_acc;
    logic [63:0] w_val_acc;
    logic [63:0] w_fix_acc;
    logic        w_fits;
    logic [CNT_W:0] w_cnt_p1;

    logic        w_bad;
    logic        w_prim;
    logic [1:0]  w_kind;
    logic [63:0] w_pval;
    logic        w_has_end;
    logic [1:0]  w_end_status;

    assign w_g      = i_data_byte[6:0];
    assign w_cont   = i_data_byte[7];
    // Seven times the byte count, the bit position of this varint group.
    assign w_sh7    = ({3'b000, r_cnt} << 3) - {3'b000, r_cnt};
    assign w_key_acc = r_key | ({25'd0, w_g} << w_sh7[5:0]);
    assign w_val_acc = r_val | ({57'd0, w_g} << w_sh7[5:0]);
    assign w_fix_acc = r_val | ({56'd0, i_data_byte} << {r_cnt[2:0], 3'b000});
    assign w_cnt_p1  = {1'b0, r_cnt} + (CNT_W+1)'(1);

    generate
        if (LENGTH_BITS >= 64) begin : g_fits_all
            assign w_fits = 1'b1;
        end else begin : g_fits_check
            assign w_fits = (w_val_acc[63:LENGTH_BITS] == '0);
        end
    endgenerate

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_key        = r_key;
        n_val        = r_val;
        n_rem        = r_rem;
        n_err        = r_err;
        w_bad        = 1'b0;
        w_prim       = 1'b0;
        w_kind       = KIND_SCALAR;
        w_pval       = '0;
        w_has_end    = 1'b0;
        w_end_status = ST_OK;

        if (r_err) begin
            // Bytes after an error are dropped until the end of the message.
            if (i_last_byte) begin
                n_phase = PH_KEY;
                n_cnt   = '0;
                n_key   = '0;
                n_val   = '0;
                n_rem   = '0;
                n_err   = 1'b0;
            end
        end else begin
            unique case (r_phase)
                PH_KEY: begin
                    if (r_cnt >= KEY_MAX_CNT && (w_g[6:4] != 3'd0 || w_cont)) begin
                        w_bad = 1'b1;
                    end else begin
                        n_key = w_key_acc;
                        if (w_cont) begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end else begin
                            n_cnt = '0;
                            n_val = '0;
                            unique case (w_key_acc[2:0])
                                WT_VARINT:              n_phase = PH_VARINT;
                                WT_FIXED64, WT_FIXED32: n_phase = PH_FIXED;
                                WT_DELIM:               n_phase = PH_LEN;
                                default:                w_bad   = 1'b1;
                            endcase
                        end
                    end
                end
                PH_VARINT, PH_LEN: begin
                    if (w_cnt_p1 >= (CNT_W+1)'(MAX_VARINT_BYTES) && w_cont) begin
                        w_bad = 1'b1;
                    end else begin
                        n_val = w_val_acc;
                        if (w_cont) begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end else if (r_phase == PH_VARINT) begin
                            w_prim  = 1'b1;
                            w_kind  = KIND_SCALAR;
                            w_pval  = w_val_acc;
                            n_phase = PH_KEY;
                            n_cnt   = '0;
                            n_key   = '0;
                            n_val   = '0;
                        end else if (!w_fits) begin
                            w_bad = 1'b1;
                        end else begin
                            w_prim = 1'b1;
                            w_kind = KIND_HEADER;
                            w_pval = w_val_acc;
                            n_cnt  = '0;
                            if (w_val_acc == '0) begin
                                // A zero-length field has its header only.
                                n_phase = PH_KEY;
                                n_key   = '0;
                                n_val   = '0;
                            end else begin
                                n_phase = PH_PAYLOAD;
                                n_rem   = w_val_acc[LENGTH_BITS-1:0];
                            end
                        end
                    end
                end
                PH_FIXED: begin
                    n_val = w_fix_acc;
                    n_cnt = r_cnt + CNT_W'(1);
                    if (n_cnt >= ((r_key[2:0] == WT_FIXED32) ? FIXED32_BYTES
                                                              : FIXED64_BYTES)) begin
                        w_prim  = 1'b1;
                        w_kind  = KIND_SCALAR;
                        w_pval  = w_fix_acc;
                        n_phase = PH_KEY;
                        n_cnt   = '0;
                        n_key   = '0;
                        n_val   = '0;
                    end
                end
                PH_PAYLOAD: begin
                    w_prim = 1'b1;
                    w_kind = KIND_PAYLOAD;
                    w_pval = {56'd0, i_data_byte};
                    n_rem  = r_rem - LENGTH_BITS'(1);
                    if (n_rem == '0) begin
                        n_phase = PH_KEY;
                        n_cnt   = '0;
                        n_key   = '0;
                        n_val   = '0;
                    end
                end
                default: begin
                    w_bad = 1'b1;
                end
            endcase

            if (w_bad) begin
                w_has_end    = 1'b1;
                w_end_status = ST_LOSS;
                n_err        = 1'b1;
            end else if (i_last_byte) begin
                w_has_end    = 1'b1;
                w_end_status = (n_phase == PH_KEY && n_cnt == '0) ? ST_EOM : ST_LOSS;
            end

            if (i_last_byte) begin
                n_phase = PH_KEY;
                n_cnt   = '0;
                n_key   = '0;
                n_val   = '0;
                n_rem   = '0;
                n_err   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KEY;
            r_cnt   <= '0;
            r_key   <= '0;
            r_val   <= '0;
            r_rem   <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_key   <= n_key;
            r_val   <= n_val;
            r_rem   <= n_rem;
            r_err   <= n_err;
        end
    end

    assign o_push                = i_accept && (w_prim || w_has_end);
    assign o_entry.has_prim      = w_prim;
    assign o_entry.kind          = w_kind;
    assign o_entry.field_number  = r_key[31:3];
    assign o_entry.wtype         = r_key[2:0];
    assign o_entry.value         = w_pval;
    assign o_entry.has_end       = w_has_end;
    assign o_entry.end_status    = w_end_status;

    a_no_push_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !o_push)
        else $error("parser pushed a result while discarding after an error");

    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD && !r_err) |-> (r_rem != '0))
        else $error("payload phase entered with no bytes remaining");

endmodule

`default_nettype wire

// File: src/pwfd_queue.sv
// Short register queue between the byte parser and the output stage.
`timescale 1ns / 1ps
`default_nettype none

module pwfd_queue
    import pwfd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_head
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_count;
    logic              w_do_pop;

    assign o_full   = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_head   = r_mem[r_rp];
    assign w_do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("entry written into a full queue");

endmodule

`default_nettype wire

// File: src/pwfd_back.sv
// Output stage: expands each queue entry into one or two results.
`timescale 1ns / 1ps
`default_nettype none

module pwfd_back
    import pwfd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire t_entry        i_head,
    output logic               o_deq,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic [1:0]         o_result_kind,
    output logic [28:0]        o_field_number,
    output logic [2:0]         o_wire_type,
    output logic [63:0]        o_value,
    output logic signed [63:0] o_signed_value,
    output logic [1:0]         o_status,
    output logic               o_last_result
);

    logic        r_sub;
    logic        w_show_end;
    logic        w_take;
    logic [63:0] w_zz;

    // The end status follows the field result of the same byte.
    assign w_show_end = r_sub || !i_head.has_prim;
    assign w_take     = i_pop && !i_q_empty;
    assign w_zz       = (i_head.value >> 1) ^ {64{i_head.value[0]}};

    assign o_empty        = i_q_empty;
    assign o_last_result  = w_show_end || !i_head.has_end;
    assign o_deq          = w_take && o_last_result;
    assign o_result_kind  = w_show_end ? KIND_END : i_head.kind;
    assign o_field_number = w_show_end ? 29'd0 : i_head.field_number;
    assign o_wire_type    = w_show_end ? WT_VARINT : i_head.wtype;
    assign o_value        = w_show_end ? 64'd0 : i_head.value;
    assign o_status       = w_show_end ? i_head.end_status : ST_OK;
    assign o_signed_value = (!w_show_end && i_head.kind == KIND_SCALAR &&
                             i_head.wtype == WT_VARINT) ? signed'(w_zz) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (w_take) begin
            r_sub <= !o_last_result;
        end
    end

    a_sub_has_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (!i_q_empty && i_head.has_prim && i_head.has_end))
        else $error("end-status step selected on an entry without two results");

endmodule

`default_nettype wire

// File: src/protobuf_wire_field_decoder.sv
// Top level of the streaming protobuf wire field decoder.
//
//  Channel   | Handshake            | Payload
//  ----------+----------------------+-----------------------------------------------
//  input     | push / full          | i_data_byte, i_last_byte
//  result    | empty / pop          | o_result_kind, o_field_number, o_wire_type,
//            |                      | o_value, o_signed_value, o_status,
//            |                      | o_last_result
//
// One byte is accepted per clock cycle while full is low; the parser updates its state in
// that same cycle, so the byte rate is one per cycle unless full stalls the input.
// Results of a byte are visible in the cycle after it is accepted when the four-entry
// queue ahead of it is empty; each pop transaction moves one result, and a byte that
// causes both a field result and an end status needs two pops to free its entry.
// full rises when four byte entries are waiting; input then stalls until the last
// result of the oldest entry is popped, and full falls in the cycle after that pop.
// Synchronous active-low reset clears the parse state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module protobuf_wire_field_decoder
    import pwfd_pkg::*;
#(
    parameter int LENGTH_BITS      = PWFD_LENGTH_BITS,
    parameter int MAX_VARINT_BYTES = PWFD_MAX_VARINT_BYTES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Input transactions.
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_last_byte,
    // Result transactions.
    output logic               empty,
    input  wire logic          pop,
    output logic [1:0]         o_result_kind,
    output logic [28:0]        o_field_number,
    output logic [2:0]         o_wire_type,
    output logic [63:0]        o_value,
    output logic signed [63:0] o_signed_value,
    output logic [1:0]         o_status,
    output logic               o_last_result
);

    logic   w_accept;
    logic   w_q_push;
    t_entry w_q_entry;
    logic   w_q_empty;
    logic   w_q_deq;
    t_entry w_q_head;

    // A byte transaction completes whenever the queue has room for its entry.
    assign w_accept = push && !full;

    // The parser classifies every byte and produces at most one entry per byte.
    pwfd_front #(
        .LENGTH_BITS      (LENGTH_BITS),
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_q_push),
        .o_entry     (w_q_entry)
    );

    // The queue decouples the parser from result back-pressure.
    pwfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_q_entry),
        .i_pop   (w_q_deq),
        .o_full  (full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    // The output stage presents the field result first, then any end status.
    pwfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_head         (w_q_head),
        .o_deq          (w_q_deq),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result_kind  (o_result_kind),
        .o_field_number (o_field_number),
        .o_wire_type    (o_wire_type),
        .o_value        (o_value),
        .o_signed_value (o_signed_value),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

endmodule

`default_nettype wire
